// ----- rtl/dsss_pkg.sv -----
// ----------------------------------------------------------------------------
// dsss_pkg
// Shared types and codes for the duplex stream start sequencer.
// ----------------------------------------------------------------------------
`default_nettype none

package dsss_pkg;

  localparam int unsigned KindW   = 4;
  localparam int unsigned FieldW  = 16;
  localparam int unsigned AnchorW = 32;
  localparam int unsigned ActW    = 4;
  localparam int unsigned PhaseW  = 3;

  // Input tdata: kind, epoch, group_count, anchor_value, zero fill to 72 bits
  localparam int unsigned InDataW  = 72;
  // Output tdata: action, anchor, main, playback, capture, confirmed, live
  localparam int unsigned OutDataW = 48;

  typedef enum logic [KindW-1:0] {
    K_BEGIN       = 4'd0,
    K_GEN_INVALID = 4'd1,
    K_CFG_OK      = 4'd2,
    K_CFG_FAIL    = 4'd3,
    K_CONN_OK     = 4'd4,
    K_CONN_FAIL   = 4'd5,
    K_ARMED       = 4'd6,
    K_ARM_FAIL    = 4'd7,
    K_DEV_OK      = 4'd8,
    K_DEV_REJECT  = 4'd9,
    K_TX_TS       = 4'd10,
    K_RX_HDR_ONLY = 4'd11,
    K_RX_USABLE   = 4'd12,
    K_CAP_EXPIRED = 4'd13,
    K_STOP        = 4'd14,
    K_RESERVED    = 4'd15
  } kind_e;

  typedef enum logic [ActW-1:0] {
    A_NONE      = 4'd0,
    A_APPLY_CFG = 4'd1,
    A_CONNECT   = 4'd2,
    A_START     = 4'd3,
    A_CONFIRM   = 4'd4,
    A_STOP_HOST = 4'd5,
    A_FAIL      = 4'd6,
    A_PLANT     = 4'd7,
    A_PUBLISH   = 4'd8,
    A_NO_DATA   = 4'd9,
    A_CAP_READY = 4'd10,
    A_CAP_DEG   = 4'd11
  } action_e;

  typedef enum logic [PhaseW-1:0] {
    PH_CFG  = 3'd0,
    PH_CONN = 3'd1,
    PH_ARM  = 3'd2,
    PH_RUN  = 3'd3,
    PH_STOP = 3'd4,
    PH_FAIL = 3'd5
  } phase_e;

  typedef enum logic [1:0] {
    PB_AWAIT_REF    = 2'd0,
    PB_AWAIT_ANCHOR = 2'd1,
    PB_RUNNING      = 2'd2
  } pb_e;

  typedef enum logic [1:0] {
    CAP_AWAIT_DATA = 2'd0,
    CAP_HDR_ONLY   = 2'd1,
    CAP_READY      = 2'd2,
    CAP_DEGRADED   = 2'd3
  } cap_e;

  localparam logic REG_CAPTURE_REF_GROUP = 1'b0;
  localparam logic REG_FIRST_CLOCK_GROUP = 1'b1;

  typedef struct packed {
    phase_e phase;
    pb_e    pb;
    cap_e   cap;
    logic   confirmed;
  } seq_state_t;

  typedef struct packed {
    logic [KindW-1:0]   kind;
    logic               epoch_match;
    logic [FieldW-1:0]  group_count;
    logic [AnchorW-1:0] anchor;
  } seq_event_t;

  typedef struct packed {
    action_e            action;
    logic [AnchorW-1:0] anchor;
  } seq_result_t;

endpackage

`default_nettype wire

// ----- rtl/duplex_stream_start_sequencer_core.sv -----
// ----------------------------------------------------------------------------
// duplex_stream_start_sequencer_core
// Start sequencer for a duplex audio stream: one event in, one result out.
// ----------------------------------------------------------------------------
//  channel   direction  ports                          item
//  s_axis    in         s_axis_tvalid/tready/tdata     event: kind, epoch, group, anchor
//  m_axis    out        m_axis_tvalid/tready/tdata     action, anchor, phases, flags
//  cfg       in         cfg_valid/ready/index/data     register write
//
//  From accept to result an item passes the event register, then the result
//  register. One item per cycle sustained while m_axis_tready is high; state
//  updates as an item moves into the result register. A stall on m_axis holds
//  both stages and drops s_axis_tready once both are full. Reset leaves the
//  sequencer stopped with epoch zero and the registers at their reset values.
// ----------------------------------------------------------------------------
`default_nettype none

module duplex_stream_start_sequencer_core
  import dsss_pkg::*;
#(
  parameter int unsigned EPOCH_BITS  = 16,
  parameter int unsigned ANCHOR_BITS = 32
) (
  input  wire logic                clk_i,
  input  wire logic                rst_ni,
  input  wire logic                s_axis_tvalid,
  output logic                     s_axis_tready,
  // [3:0] kind, [19:4] epoch, [35:20] group_count, [67:36] anchor_value
  input  wire logic [InDataW-1:0]  s_axis_tdata,
  output logic                     m_axis_tvalid,
  input  wire logic                m_axis_tready,
  // [3:0] action, [35:4] action_anchor, [38:36] main_phase,
  // [40:39] playback_phase, [42:41] capture_phase, [43] start_confirmed,
  // [44] playback_live
  output logic [OutDataW-1:0]      m_axis_tdata,
  input  wire logic                cfg_valid,
  output logic                     cfg_ready,
  input  wire logic                cfg_index,
  input  wire logic [FieldW-1:0]   cfg_data
);

  localparam int unsigned EpW = (EPOCH_BITS < FieldW) ? EPOCH_BITS : FieldW;
  localparam int unsigned AnW = (ANCHOR_BITS < AnchorW) ? ANCHOR_BITS : AnchorW;

  logic [FieldW-1:0] capture_ref_group_q;
  logic [FieldW-1:0] first_clock_group_q;

  logic              ev_valid_q;
  logic [KindW-1:0]  ev_kind_q;
  logic [EpW-1:0]    ev_epoch_q;
  logic [FieldW-1:0] ev_group_q;
  logic [AnW-1:0]    ev_anchor_q;

  logic [EpW-1:0]    epoch_q;
  seq_state_t        state_q;
  seq_state_t        state_d;
  seq_event_t        evt;
  seq_result_t       res;

  logic                out_valid_q;
  logic [OutDataW-1:0] out_data_q;
  logic [OutDataW-1:0] out_data_d;

  logic out_load;
  logic ev_load;

  assign out_load      = ev_valid_q && (!out_valid_q || m_axis_tready);
  assign s_axis_tready = !ev_valid_q || out_load;
  assign ev_load       = s_axis_tvalid && s_axis_tready;
  assign cfg_ready     = 1'b1;

  assign evt.kind        = ev_kind_q;
  assign evt.epoch_match = (ev_epoch_q == epoch_q);
  assign evt.group_count = ev_group_q;
  assign evt.anchor      = AnchorW'(ev_anchor_q);

  dsss_step u_step (
    .cur_i               (state_q),
    .evt_i               (evt),
    .capture_ref_group_i (capture_ref_group_q),
    .first_clock_group_i (first_clock_group_q),
    .nxt_o               (state_d),
    .res_o               (res)
  );

  always_comb begin
    out_data_d        = '0;
    out_data_d[3:0]   = res.action;
    out_data_d[35:4]  = res.anchor;
    out_data_d[38:36] = state_d.phase;
    out_data_d[40:39] = state_d.pb;
    out_data_d[42:41] = state_d.cap;
    out_data_d[43]    = (state_d.phase == PH_RUN) && state_d.confirmed;
    out_data_d[44]    = (state_d.phase == PH_RUN) && (state_d.pb == PB_RUNNING);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      capture_ref_group_q <= 16'd1;
      first_clock_group_q <= 16'd2;
    end else if (cfg_valid && cfg_ready) begin
      if (cfg_index == REG_CAPTURE_REF_GROUP) begin
        capture_ref_group_q <= cfg_data;
      end else begin
        first_clock_group_q <= cfg_data;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ev_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
      epoch_q     <= '0;
      state_q     <= '{phase: PH_STOP, pb: PB_AWAIT_REF, cap: CAP_AWAIT_DATA,
                       confirmed: 1'b0};
    end else begin
      if (ev_load) begin
        ev_valid_q <= 1'b1;
      end else if (out_load) begin
        ev_valid_q <= 1'b0;
      end
      if (out_load) begin
        out_valid_q <= 1'b1;
        state_q     <= state_d;
        if (ev_kind_q == K_BEGIN) begin
          epoch_q <= ev_epoch_q;
        end
      end else if (m_axis_tready) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (ev_load) begin
      ev_kind_q   <= s_axis_tdata[3:0];
      ev_epoch_q  <= s_axis_tdata[4 +: EpW];
      ev_group_q  <= s_axis_tdata[35:20];
      ev_anchor_q <= s_axis_tdata[36 +: AnW];
    end
    if (out_load) begin
      out_data_q <= out_data_d;
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = out_data_q;

endmodule

`default_nettype wire

// ----- rtl/dsss_step.sv -----
// ----------------------------------------------------------------------------
// dsss_step
// Next-state and action logic for one event of the start sequencer.
// ----------------------------------------------------------------------------
`default_nettype none

module dsss_step
  import dsss_pkg::*;
(
  input  var seq_state_t         cur_i,
  input  var seq_event_t         evt_i,
  input  wire logic [FieldW-1:0] capture_ref_group_i,
  input  wire logic [FieldW-1:0] first_clock_group_i,
  output seq_state_t             nxt_o,
  output seq_result_t            res_o
);

  logic terminal;
  logic live;

  assign terminal = (cur_i.phase == PH_STOP) || (cur_i.phase == PH_FAIL);
  assign live     = (cur_i.phase == PH_ARM) || (cur_i.phase == PH_RUN);

  always_comb begin
    nxt_o            = cur_i;
    res_o.action     = A_NONE;
    res_o.anchor     = '0;

    case (evt_i.kind)
      K_BEGIN: begin
        nxt_o.phase     = PH_CFG;
        nxt_o.pb        = PB_AWAIT_REF;
        nxt_o.cap       = CAP_AWAIT_DATA;
        nxt_o.confirmed = 1'b0;
        res_o.action    = A_APPLY_CFG;
      end
      K_GEN_INVALID: begin
        if (!terminal) begin
          nxt_o.phase     = PH_STOP;
          nxt_o.pb        = PB_AWAIT_REF;
          nxt_o.cap       = CAP_AWAIT_DATA;
          nxt_o.confirmed = 1'b0;
          res_o.action    = live ? A_STOP_HOST : A_NONE;
        end
      end
      default: begin
        // stale epoch, terminal phase or unused kind: ignored
        if (!terminal && evt_i.epoch_match && evt_i.kind != K_RESERVED) begin
          if (evt_i.kind == K_STOP) begin
            nxt_o.phase     = PH_STOP;
            nxt_o.pb        = PB_AWAIT_REF;
            nxt_o.cap       = CAP_AWAIT_DATA;
            nxt_o.confirmed = 1'b0;
            res_o.action    = live ? A_STOP_HOST : A_NONE;
          end else if (cur_i.phase == PH_CFG) begin
            if (evt_i.kind == K_CFG_OK) begin
              nxt_o.phase  = PH_CONN;
              res_o.action = A_CONNECT;
            end else if (evt_i.kind == K_CFG_FAIL) begin
              nxt_o.phase     = PH_FAIL;
              nxt_o.pb        = PB_AWAIT_REF;
              nxt_o.cap       = CAP_AWAIT_DATA;
              nxt_o.confirmed = 1'b0;
              res_o.action    = A_FAIL;
            end
          end else if (cur_i.phase == PH_CONN) begin
            if (evt_i.kind == K_CONN_OK) begin
              nxt_o.phase     = PH_ARM;
              nxt_o.pb        = PB_AWAIT_REF;
              nxt_o.cap       = CAP_AWAIT_DATA;
              nxt_o.confirmed = 1'b0;
              res_o.action    = A_START;
            end else if (evt_i.kind == K_CONN_FAIL) begin
              nxt_o.phase     = PH_FAIL;
              nxt_o.pb        = PB_AWAIT_REF;
              nxt_o.cap       = CAP_AWAIT_DATA;
              nxt_o.confirmed = 1'b0;
              res_o.action    = A_FAIL;
            end
          end else begin
            // arming or running
            if (cur_i.phase == PH_ARM && evt_i.kind == K_ARMED) begin
              nxt_o.phase     = PH_RUN;
              nxt_o.confirmed = 1'b0;
              res_o.action    = A_CONFIRM;
            end else if ((cur_i.phase == PH_ARM && evt_i.kind == K_ARM_FAIL) ||
                         (cur_i.phase == PH_RUN && evt_i.kind == K_DEV_REJECT &&
                          !cur_i.confirmed)) begin
              nxt_o.phase     = PH_FAIL;
              nxt_o.pb        = PB_AWAIT_REF;
              nxt_o.cap       = CAP_AWAIT_DATA;
              nxt_o.confirmed = 1'b0;
              res_o.action    = A_STOP_HOST;
            end else if (cur_i.phase == PH_RUN && evt_i.kind == K_DEV_OK) begin
              nxt_o.confirmed = 1'b1;
            end else if (evt_i.kind == K_TX_TS) begin
              if (cur_i.pb == PB_AWAIT_REF) begin
                if (evt_i.group_count == capture_ref_group_i) begin
                  nxt_o.pb     = PB_AWAIT_ANCHOR;
                  res_o.action = A_PLANT;
                  res_o.anchor = evt_i.anchor;
                end
              end else if (!(cur_i.pb == PB_AWAIT_ANCHOR &&
                             evt_i.group_count < first_clock_group_i)) begin
                nxt_o.pb     = PB_RUNNING;
                res_o.action = A_PUBLISH;
                res_o.anchor = evt_i.anchor;
              end
            end else if (evt_i.kind == K_RX_HDR_ONLY) begin
              if (cur_i.cap == CAP_AWAIT_DATA) begin
                nxt_o.cap    = CAP_HDR_ONLY;
                res_o.action = A_NO_DATA;
              end
            end else if (evt_i.kind == K_RX_USABLE) begin
              if (cur_i.cap != CAP_READY) begin
                nxt_o.cap    = CAP_READY;
                res_o.action = A_CAP_READY;
              end
            end else if (evt_i.kind == K_CAP_EXPIRED) begin
              if (cur_i.cap == CAP_AWAIT_DATA || cur_i.cap == CAP_HDR_ONLY) begin
                nxt_o.cap    = CAP_DEGRADED;
                res_o.action = A_CAP_DEG;
              end
            end
          end
        end
      end
    endcase
  end

endmodule

`default_nettype wire
